// ===== hdl/rrcc_pkg.sv =====
`default_nettype none

package rrcc_pkg;

    // Configuration register indexes
    localparam logic CFG_MAX_BULK_LENGTH   = 1'b0;
    localparam logic CFG_MAX_ELEMENT_COUNT = 1'b1;

    // Reset values of the limit registers
    localparam logic [31:0] MAX_BULK_LENGTH_RESET   = 32'd536870912;
    localparam logic [31:0] MAX_ELEMENT_COUNT_RESET = 32'd1048576;

    // Saturation limits
    localparam logic [32:0] NUM_SAT = 33'h1_FFFF_FFFF;
    localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;

    // Protocol characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_NEED_MORE = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_ERROR     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_LINE      = 2'd0,
        KIND_BULK      = 2'd1,
        KIND_MULTIBULK = 2'd2
    } kind_t;

    typedef enum logic [10:0] {
        PH_TYPE      = 11'b000_0000_0001,
        PH_LINE      = 11'b000_0000_0010,
        PH_LINE_LF   = 11'b000_0000_0100,
        PH_NUM_SIGN  = 11'b000_0000_1000,
        PH_NUM_NEG   = 11'b000_0001_0000,
        PH_NUM_MORE  = 11'b000_0010_0000,
        PH_NUM_LF    = 11'b000_0100_0000,
        PH_PAYLOAD   = 11'b000_1000_0000,
        PH_PAY_CR    = 11'b001_0000_0000,
        PH_PAY_LF    = 11'b010_0000_0000,
        PH_ELEM_MARK = 11'b100_0000_0000
    } phase_t;

endpackage

`default_nettype wire

// ===== hdl/resp_reply_completeness_check.sv =====
`default_nettype none
// Channel   Handshake                Payload
// request   req_valid / req_stall    data_byte, start_of_reply, end_of_buffer
// result    res_valid / res_stall    status, reply_kind, reply_length
// config    cfg_we                   cfg_index, cfg_data
//
// One byte per cycle while req_stall is low: a request is latched into the input
// register, parsed by combinational logic, and its result (if any) lands in the
// result register when the byte leaves the input register.
// rst_n clears the parser state, the valid bits and the limits to their defaults.
// A stalled result holds the pipeline; req_stall rises only while a byte waits
// in the input register behind a full, stalled result register.

module resp_reply_completeness_check
    import rrcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_reply,
    input  wire logic        end_of_buffer,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic [1:0]       reply_kind,
    output logic [31:0]      reply_length,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       in_eob_reg;

    // Limits
    logic [31:0] max_bulk_reg;
    logic [31:0] max_elem_reg;

    // Parser state
    phase_t      phase_reg,    phase_next;
    logic [32:0] num_reg,      num_next;
    logic        neg_reg,      neg_next;
    logic [31:0] pay_left_reg, pay_left_next;
    logic [31:0] elem_left_reg, elem_left_next;
    logic        in_multi_reg, in_multi_next;
    kind_t       kind_reg,     kind_next;
    logic [31:0] seen_reg,     seen_next;

    // Result register
    logic        res_valid_reg;
    status_t     status_reg;
    kind_t       kind_out_reg;
    logic [31:0] length_reg;

    logic        advance;
    logic        req_accept;
    status_t     ev;
    logic        emit;

    logic        is_digit;
    logic [36:0] num_prod;
    logic [32:0] digit_value;
    logic [32:0] elem_dec;
    logic        num_is_count;

    // Advance when a byte waits and the result register can be refilled
    assign advance    = in_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall  = in_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;

    // Hold the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= start_of_reply;
            in_eob_reg   <= end_of_buffer;
        end
    end

    // Write the limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg <= MAX_BULK_LENGTH_RESET;
            max_elem_reg <= MAX_ELEMENT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_BULK_LENGTH:   max_bulk_reg <= cfg_data;
                CFG_MAX_ELEMENT_COUNT: max_elem_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Decimal digit accumulate, saturating at 2^33-1
    assign is_digit    = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit_value = {29'd0, in_byte_reg[3:0]};
    assign num_prod    = {1'b0, num_reg, 3'b000} + {3'b000, num_reg, 1'b0}
                         + {4'd0, digit_value};
    assign elem_dec    = {1'b0, elem_left_reg} - 33'd1;
    assign num_is_count = (kind_reg == KIND_MULTIBULK) && !in_multi_reg;

    // Parse one byte
    always_comb
    begin
        phase_t ph;

        ph             = in_start_reg ? PH_TYPE : phase_reg;
        phase_next     = ph;
        num_next       = num_reg;
        neg_next       = neg_reg;
        pay_left_next  = pay_left_reg;
        elem_left_next = elem_left_reg;
        in_multi_next  = in_multi_reg;
        kind_next      = kind_reg;
        seen_next      = seen_reg;
        ev             = ST_NEED_MORE;

        if (ph == PH_TYPE)
        begin
            num_next       = '0;
            neg_next       = 1'b0;
            pay_left_next  = '0;
            elem_left_next = '0;
            in_multi_next  = 1'b0;
            kind_next      = KIND_LINE;
            seen_next      = 32'd1;
        end
        else if (seen_reg != LEN_SAT)
        begin
            seen_next = seen_reg + 32'd1;
        end

        case (ph)
            PH_TYPE:
            begin
                if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS ||
                    in_byte_reg == CH_COLON)
                begin
                    kind_next  = KIND_LINE;
                    phase_next = PH_LINE;
                end
                else if (in_byte_reg == CH_DOLLAR)
                begin
                    kind_next  = KIND_BULK;
                    phase_next = PH_NUM_SIGN;
                end
                else if (in_byte_reg == CH_STAR)
                begin
                    kind_next  = KIND_MULTIBULK;
                    phase_next = PH_NUM_SIGN;
                end
                else
                begin
                    ev = ST_ERROR;
                end
            end
            PH_LINE:
            begin
                if (in_byte_reg == CH_CR)
                begin
                    phase_next = PH_LINE_LF;
                end
            end
            PH_LINE_LF:
            begin
                if (in_byte_reg == CH_LF)
                begin
                    ev = ST_COMPLETE;
                end
                else if (in_byte_reg != CH_CR)
                begin
                    phase_next = PH_LINE;
                end
            end
            PH_NUM_SIGN, PH_NUM_NEG, PH_NUM_MORE:
            begin
                if (ph == PH_NUM_SIGN && in_byte_reg == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_NUM_NEG;
                end
                else if (ph == PH_NUM_MORE && in_byte_reg == CH_CR)
                begin
                    // Check the finished number
                    phase_next = PH_NUM_LF;
                    if (neg_reg)
                    begin
                        if (num_reg != 33'd1)
                        begin
                            ev = ST_ERROR;
                        end
                    end
                    else if (num_is_count)
                    begin
                        if (num_reg > {1'b0, max_elem_reg})
                        begin
                            ev = ST_ERROR;
                        end
                    end
                    else if (num_reg > {1'b0, max_bulk_reg})
                    begin
                        ev = ST_ERROR;
                    end
                end
                else if (is_digit)
                begin
                    phase_next = PH_NUM_MORE;
                    num_next   = (num_prod > {4'd0, NUM_SAT}) ? NUM_SAT : num_prod[32:0];
                end
                else
                begin
                    ev = ST_ERROR;
                end
            end
            PH_NUM_LF:
            begin
                // Act on the number
                if (num_is_count)
                begin
                    if (neg_reg || num_reg == 33'd0)
                    begin
                        ev = ST_COMPLETE;
                    end
                    else
                    begin
                        elem_left_next = num_reg[31:0];
                        in_multi_next  = 1'b1;
                        phase_next     = PH_ELEM_MARK;
                    end
                end
                else if (neg_reg)
                begin
                    if (kind_reg == KIND_BULK)
                    begin
                        ev = ST_COMPLETE;
                    end
                    else
                    begin
                        elem_left_next = elem_dec[31:0];
                        if (elem_dec[31:0] == 32'd0)
                        begin
                            ev = ST_COMPLETE;
                        end
                        else
                        begin
                            phase_next = PH_ELEM_MARK;
                        end
                    end
                end
                else
                begin
                    pay_left_next = num_reg[31:0];
                    phase_next    = (num_reg[31:0] != 32'd0) ? PH_PAYLOAD : PH_PAY_CR;
                end
            end
            PH_PAYLOAD:
            begin
                pay_left_next = pay_left_reg - 32'd1;
                if (pay_left_next == 32'd0)
                begin
                    phase_next = PH_PAY_CR;
                end
            end
            PH_PAY_CR:
            begin
                phase_next = PH_PAY_LF;
            end
            PH_PAY_LF:
            begin
                if (kind_reg == KIND_BULK)
                begin
                    ev = ST_COMPLETE;
                end
                else
                begin
                    elem_left_next = elem_dec[31:0];
                    if (elem_dec[31:0] == 32'd0)
                    begin
                        ev = ST_COMPLETE;
                    end
                    else
                    begin
                        phase_next = PH_ELEM_MARK;
                    end
                end
            end
            PH_ELEM_MARK:
            begin
                num_next   = '0;
                neg_next   = 1'b0;
                phase_next = PH_NUM_SIGN;
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase

        // A finished or failed reply makes the next byte a type byte
        if (ev != ST_NEED_MORE)
        begin
            phase_next = PH_TYPE;
        end
    end

    assign emit = (ev != ST_NEED_MORE) || in_eob_reg;

    // Advance the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            pay_left_reg  <= '0;
            elem_left_reg <= '0;
            in_multi_reg  <= 1'b0;
            kind_reg      <= KIND_LINE;
            seen_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            pay_left_reg  <= pay_left_next;
            elem_left_reg <= elem_left_next;
            in_multi_reg  <= in_multi_next;
            kind_reg      <= kind_next;
            seen_reg      <= seen_next;
        end
    end

    // Load or drop the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= emit;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg   <= ev;
            kind_out_reg <= kind_next;
            length_reg   <= seen_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign reply_kind   = kind_out_reg;
    assign reply_length = length_reg;

endmodule

`default_nettype wire

// ===== test/tb_resp_reply_completeness_check.sv =====
`timescale 1ns / 100ps

module tb_resp_reply_completeness_check;
    import rrcc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        bit         sor;
        bit         eob;
    } req_t;

    typedef struct packed {
        status_t     st;
        kind_t       kind;
        logic [31:0] len;
    } verdict_t;

    // One opening request: typed rows carry their own verdict, the rest use the predictor
    typedef struct packed {
        logic [7:0]  data;
        bit          sor;
        bit          eob;
        bit          typed;
        bit          yields;
        status_t     st;
        kind_t       kind;
        logic [31:0] len;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        start_of_reply = 1'b0;
    logic        end_of_buffer = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  status;
    logic [1:0]  reply_kind;
    logic [31:0] reply_length;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'h0;

    // Framing predictor state and its copy of the limits
    phase_t      fr_phase = PH_TYPE;
    logic [32:0] acc_value = '0;
    bit          acc_negative = 1'b0;
    logic [31:0] body_left = '0;
    logic [31:0] elems_left = '0;
    bit          in_array = 1'b0;
    kind_t       fr_kind = KIND_LINE;
    logic [31:0] fr_count = '0;
    logic [31:0] lim_bulk = MAX_BULK_LENGTH_RESET;
    logic [31:0] lim_elems = MAX_ELEMENT_COUNT_RESET;

    verdict_t expected_verdicts[$];
    req_t     reply_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int bytes_sent = 0;
    int verdicts_checked = 0;
    int failures = 0;
    int limit_settings = 1;
    int n_complete = 0;
    int n_error = 0;
    int n_need = 0;

    script_row_t opening_script [31] = '{
        // unknown type bytes, the second one right after an error
        '{8'h00,     1'b1, 1'b0, 1'b1, 1'b1, ST_ERROR,     KIND_LINE,      32'd1},
        '{8'hFF,     1'b0, 1'b0, 1'b1, 1'b1, ST_ERROR,     KIND_LINE,      32'd1},
        // one-line reply, a CR not followed by LF keeps it open
        '{CH_PLUS,   1'b1, 1'b1, 1'b1, 1'b1, ST_NEED_MORE, KIND_LINE,      32'd1},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h80,     1'b0, 1'b1, 1'b1, 1'b1, ST_NEED_MORE, KIND_LINE,      32'd3},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_LF,     1'b0, 1'b0, 1'b1, 1'b1, ST_COMPLETE,  KIND_LINE,      32'd5},
        // empty multibulk without start flag, unchecked byte after CR
        '{CH_STAR,   1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_ZERO,   1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h41,     1'b0, 1'b0, 1'b1, 1'b1, ST_COMPLETE,  KIND_MULTIBULK, 32'd4},
        // multibulk of one null element, odd marker byte
        '{CH_STAR,   1'b1, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h31,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_LF,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h5A,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_MINUS,  1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h31,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_LF,     1'b0, 1'b0, 1'b1, 1'b1, ST_COMPLETE,  KIND_MULTIBULK, 32'd9},
        // bulk of one byte, terminator bytes not checked
        '{CH_DOLLAR, 1'b1, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h31,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_CR,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_LF,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h71,     1'b0, 1'b1, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'h00,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{8'hFF,     1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        // negative length other than -1
        '{CH_DOLLAR, 1'b1, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_MINUS,  1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_NINE,   1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_MORE, KIND_LINE,      32'd0},
        '{CH_CR,     1'b0, 1'b0, 1'b1, 1'b1, ST_ERROR,     KIND_BULK,      32'd4}
    };

    resp_reply_completeness_check DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .data_byte      (data_byte),
        .start_of_reply (start_of_reply),
        .end_of_buffer  (end_of_buffer),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .status         (status),
        .reply_kind     (reply_kind),
        .reply_length   (reply_length),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void begin_number();
        acc_value = '0;
        acc_negative = 1'b0;
        fr_phase = PH_NUM_SIGN;
    endfunction

    // Accumulate one decimal digit, saturating at the 33-bit ceiling
    function automatic status_t take_digit(logic [7:0] b);
        logic [32:0] d;
        if (b < CH_ZERO || b > CH_NINE)
            return ST_ERROR;
        d = {25'd0, b - CH_ZERO};
        if (acc_value > (NUM_SAT - d) / 33'd10)
            acc_value = NUM_SAT;
        else
            acc_value = acc_value * 33'd10 + d;
        fr_phase = PH_NUM_MORE;
        return ST_NEED_MORE;
    endfunction

    function automatic status_t close_element();
        elems_left = elems_left - 32'd1;
        if (elems_left == 32'd0)
            return ST_COMPLETE;
        fr_phase = PH_ELEM_MARK;
        return ST_NEED_MORE;
    endfunction

    task automatic frame_byte(input logic [7:0] b, input bit sor, input bit eob,
                              output bit yields, output verdict_t v);
        status_t ev;
        bit      counting;
        ev = ST_NEED_MORE;
        if (sor)
            fr_phase = PH_TYPE;
        if (fr_phase == PH_TYPE)
        begin
            acc_value = '0;
            acc_negative = 1'b0;
            body_left = '0;
            elems_left = '0;
            in_array = 1'b0;
            fr_kind = KIND_LINE;
            fr_count = 32'd1;
        end
        else if (fr_count != LEN_SAT)
        begin
            fr_count = fr_count + 32'd1;
        end
        counting = fr_kind == KIND_MULTIBULK && !in_array;

        case (fr_phase)
            PH_TYPE:
            begin
                if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON)
                begin
                    fr_kind = KIND_LINE;
                    fr_phase = PH_LINE;
                end
                else if (b == CH_DOLLAR)
                begin
                    fr_kind = KIND_BULK;
                    begin_number();
                end
                else if (b == CH_STAR)
                begin
                    fr_kind = KIND_MULTIBULK;
                    begin_number();
                end
                else
                begin
                    ev = ST_ERROR;
                end
            end
            PH_LINE:
            begin
                if (b == CH_CR)
                    fr_phase = PH_LINE_LF;
            end
            PH_LINE_LF:
            begin
                if (b == CH_LF)
                    ev = ST_COMPLETE;
                else if (b != CH_CR)
                    fr_phase = PH_LINE;
            end
            PH_NUM_SIGN:
            begin
                if (b == CH_MINUS)
                begin
                    acc_negative = 1'b1;
                    fr_phase = PH_NUM_NEG;
                end
                else
                begin
                    ev = take_digit(b);
                end
            end
            PH_NUM_NEG:
            begin
                ev = take_digit(b);
            end
            PH_NUM_MORE:
            begin
                // range checks happen on the CR
                if (b == CH_CR)
                begin
                    if (acc_negative)
                        ev = (acc_value == 33'd1) ? ST_NEED_MORE : ST_ERROR;
                    else if (acc_value > {1'b0, counting ? lim_elems : lim_bulk})
                        ev = ST_ERROR;
                    fr_phase = PH_NUM_LF;
                end
                else
                begin
                    ev = take_digit(b);
                end
            end
            PH_NUM_LF:
            begin
                // act on the number; this byte itself is not checked
                if (counting)
                begin
                    if (acc_negative || acc_value == 33'd0)
                    begin
                        ev = ST_COMPLETE;
                    end
                    else
                    begin
                        elems_left = acc_value[31:0];
                        in_array = 1'b1;
                        fr_phase = PH_ELEM_MARK;
                    end
                end
                else if (acc_negative)
                begin
                    if (fr_kind == KIND_BULK)
                        ev = ST_COMPLETE;
                    else
                        ev = close_element();
                end
                else
                begin
                    body_left = acc_value[31:0];
                    fr_phase = (body_left != 32'd0) ? PH_PAYLOAD : PH_PAY_CR;
                end
            end
            PH_PAYLOAD:
            begin
                body_left = body_left - 32'd1;
                if (body_left == 32'd0)
                    fr_phase = PH_PAY_CR;
            end
            PH_PAY_CR:
            begin
                fr_phase = PH_PAY_LF;
            end
            PH_PAY_LF:
            begin
                if (fr_kind == KIND_BULK)
                    ev = ST_COMPLETE;
                else
                    ev = close_element();
            end
            default:
            begin
                begin_number();
            end
        endcase

        yields = ev != ST_NEED_MORE || eob;
        if (ev != ST_NEED_MORE)
            fr_phase = PH_TYPE;
        v = '{ev, fr_kind, fr_count};
    endtask

    // ---------------------------------------------------------------- driving

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%s", what);
    endtask

    // Offer one request byte, hold it until accepted, then record its verdict
    task automatic send_request(input req_t r, input bit typed, input bit typed_yields,
                                input verdict_t typed_v);
        bit       yields;
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        data_byte <= r.data;
        start_of_reply <= r.sor;
        end_of_buffer <= r.eob;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        frame_byte(r.data, r.sor, r.eob, yields, v);
        if (typed)
        begin
            yields = typed_yields;
            v = typed_v;
        end
        if (yields)
        begin
            expected_verdicts.push_back(v);
            case (v.st)
                ST_COMPLETE: n_complete++;
                ST_ERROR:    n_error++;
                default:     n_need++;
            endcase
        end
        bytes_sent++;
    endtask

    // Stop offering, wait for all verdicts, then let the pipeline empty
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_BULK_LENGTH)
            lim_bulk = value;
        else
            lim_elems = value;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------- reply generator

    task automatic add_byte(input logic [7:0] b);
        reply_bytes.push_back('{b, 1'b0, 1'($urandom_range(99) < 8)});
    endtask

    task automatic add_number(input longint unsigned value);
        string s;
        s = $sformatf("%0d", value);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Length line; body is the payload size, -1 for null, -2 when the reply should stop
    task automatic add_length(input int small_max, output int body);
        int pick;
        int digit;
        pick = $urandom_range(99);
        if (pick < 84)
        begin
            body = $urandom_range(small_max);
            if ($urandom_range(9) == 0)
                add_byte(CH_ZERO);
            add_number(body);
        end
        else if (pick < 90)
        begin
            add_byte(CH_MINUS);
            add_byte(CH_ZERO + 8'd1);
            body = -1;
        end
        else if (pick < 95)
        begin
            // malformed: bad negative, stray byte, or no digit at all
            case ($urandom_range(2))
                0:
                begin
                    digit = $urandom_range(8);
                    if (digit >= 1)
                        digit++;
                    add_byte(CH_MINUS);
                    add_byte(CH_ZERO + 8'(digit));
                end
                1: add_byte(8'($urandom));
                default: ;
            endcase
            body = -2;
        end
        else if (pick < 98)
        begin
            // ten to twelve digits, often past any 32-bit limit, sometimes past the accumulator ceiling
            add_byte(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(9, 11))
                add_byte(CH_ZERO + 8'($urandom_range(9)));
            body = -2;
        end
        else
        begin
            add_number(64'd4294967295 + 64'($urandom_range(1)));
            body = -2;
        end
        add_byte(CH_CR);
        add_byte(($urandom_range(9) == 0) ? 8'($urandom) : CH_LF);
    endtask

    task automatic add_element(output bit halted);
        int n;
        add_length(8, n);
        if (n > 0)
            repeat (n) add_byte(8'($urandom));
        if (n >= 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_byte(8'($urandom));
                add_byte(8'($urandom));
            end
            else
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        end
        halted = n == -2;
    endtask

    // Set the limits, then stream random replies until the byte budget is spent
    task automatic run_phase(input logic [31:0] bulk_lim, input logic [31:0] elem_lim,
                             input int send_pct, input int recv_pct, input int budget);
        int   target;
        int   pick;
        int   n;
        int   keep;
        int   idx;
        bit   halted;
        bit   noise;
        req_t r;
        drain();
        write_reg(CFG_MAX_BULK_LENGTH, bulk_lim);
        write_reg(CFG_MAX_ELEMENT_COUNT, elem_lim);
        limit_settings++;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = bytes_sent + budget;
        while (bytes_sent < target)
        begin
            reply_bytes.delete();
            noise = 1'b0;
            halted = 1'b0;
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                case ($urandom_range(2))
                    0: add_byte(CH_PLUS);
                    1: add_byte(CH_MINUS);
                    default: add_byte(CH_COLON);
                endcase
                repeat ($urandom_range(6)) add_byte(8'($urandom));
                if ($urandom_range(9) == 0)
                begin
                    add_byte(CH_CR);
                    add_byte(8'($urandom));
                end
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            else if (pick < 58)
            begin
                add_byte(CH_DOLLAR);
                add_element(halted);
            end
            else if (pick < 85)
            begin
                add_byte(CH_STAR);
                add_length(4, n);
                for (int i = 0; i < n && !halted; i++)
                begin
                    add_byte(($urandom_range(9) == 0) ? 8'($urandom) : CH_DOLLAR);
                    add_element(halted);
                end
            end
            else
            begin
                noise = 1'b1;
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            end

            // break some well-formed replies: cut short or corrupt one byte
            pick = $urandom_range(99);
            if (!noise && pick < 8)
            begin
                keep = $urandom_range(1, reply_bytes.size());
                while (reply_bytes.size() > keep)
                    void'(reply_bytes.pop_back());
            end
            else if (!noise && pick < 15)
            begin
                idx = $urandom_range(reply_bytes.size() - 1);
                r = reply_bytes[idx];
                r.data = 8'($urandom);
                reply_bytes[idx] = r;
            end

            foreach (reply_bytes[i])
            begin
                r = reply_bytes[i];
                if (noise)
                    r.sor = $urandom_range(1);
                else if (i == 0)
                    r.sor = $urandom_range(99) < 85;
                if (i == reply_bytes.size() - 1 && $urandom_range(2) == 0)
                    r.eob = 1'b1;
                send_request(r, 1'b0, 1'b0, '{ST_NEED_MORE, KIND_LINE, 32'd0});
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Result stall: random, or a long hold-off when one is requested
    initial
    begin : result_stall
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left = 64;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Compare each accepted verdict with the oldest one predicted
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                note_failure($sformatf("unexpected verdict: status %0d kind %0d length %0d",
                                       status, reply_kind, reply_length));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (status !== want.st || reply_kind !== want.kind
                    || reply_length !== want.len)
                    note_failure($sformatf({"verdict differs: expected status %0d kind %0d ",
                                            "length %0d, got status %0d kind %0d length %0d"},
                                           want.st, want.kind, want.len,
                                           status, reply_kind, reply_length));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int waited;
        req_t r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening script under the reset limits
        foreach (opening_script[i])
            send_request('{opening_script[i].data, opening_script[i].sor,
                           opening_script[i].eob},
                         opening_script[i].typed, opening_script[i].yields,
                         '{opening_script[i].st, opening_script[i].kind,
                           opening_script[i].len});

        run_phase(32'd6, 32'd3, 7, 59, 480);
        run_phase(32'd0, 32'd0, 59, 7, 480);
        run_phase(LEN_SAT, LEN_SAT, 0, 0, 480);

        // fill the block behind a long result hold-off, then pause until it empties
        drain();
        hold_requests++;
        repeat (30)
        begin
            r = '{8'($urandom), 1'b0, 1'b1};
            send_request(r, 1'b0, 1'b0, '{ST_NEED_MORE, KIND_LINE, 32'd0});
        end
        drain();

        run_phase(32'd2, 32'd1, 0, 0, 480);

        // wait out the tail
        req_valid <= 1'b0;
        waited = 0;
        while (expected_verdicts.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_verdicts.size() != 0)
            note_failure($sformatf("%0d predicted verdicts never arrived",
                                   expected_verdicts.size()));

        $display("covered %0d request bytes under %0d limit settings, with idle and hold-off",
                 bytes_sent, limit_settings);
        $display("checked %0d verdicts: %0d complete, %0d error, %0d need more",
                 verdicts_checked, n_complete, n_error, n_need);
        if (failures == 0)
            $display("resp_reply_completeness_check: match");
        else
            $display("resp_reply_completeness_check: mismatch");
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #4000000;
        $display("resp_reply_completeness_check: mismatch");
        $finish;
    end

endmodule
